// ===== src/tbs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tone burst sequencer package
// Shared constants, register indexes and the quarter-wave sine table.
// ----------------------------------------------------------------------------
package tbs_pkg;

  localparam int unsigned PHASE_BITS       = 16;
  localparam int unsigned SINE_TABLE_DEPTH = 256;
  localparam int unsigned MAX_PIPS         = 15;

  localparam int unsigned QUAD_BITS  = PHASE_BITS - 2;
  localparam int unsigned IDX_BITS   = $clog2(SINE_TABLE_DEPTH);
  localparam int unsigned ROM_AW     = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int unsigned BEEP_W     = $clog2(MAX_PIPS + 1);
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned AMP_W      = 15;
  localparam int unsigned ROM_W      = 15;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TONE_AMPLITUDE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TONE_LENGTH    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_LENGTH     = 2'd3;

  localparam logic [15:0]      RST_PHASE_STEP     = 16'd4096;
  localparam logic [AMP_W-1:0] RST_TONE_AMPLITUDE = 15'd16384;
  localparam logic [15:0]      RST_TONE_LENGTH    = 16'd1600;
  localparam logic [15:0]      RST_GAP_LENGTH     = 16'd1600;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned FULL_SCALE  = 64'd32767;

  typedef logic [ROM_W-1:0] sine_rom_t [SINE_TABLE_DEPTH+1];

  // Quarter-wave table from a truncated Taylor series in Q30, rounded to Q0.15.
  // Evaluated once at elaboration.
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t       rom;
    longint unsigned x;
    longint unsigned term;
    longint          sum;
    longint          v;
    for (int k = 0; k <= int'(SINE_TABLE_DEPTH); k++) begin
      x    = (64'(k) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 7; n++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / 64'((2 * n) * (2 * n + 1));
        if ((n % 2) == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      v = longint'((unsigned'(sum) * FULL_SCALE + (64'd1 << 29)) >> 30);
      if (v > longint'(FULL_SCALE)) begin
        v = longint'(FULL_SCALE);
      end
      rom[k] = v[ROM_W-1:0];
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

// ===== src/tbs_sine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tone burst sine shaper
// Maps a phase onto the quarter-wave table and scales it by the amplitude.
// ----------------------------------------------------------------------------
module tbs_sine
  import tbs_pkg::*;
(
  input  logic [PHASE_BITS-1:0]      phase_i,
  input  logic [AMP_W-1:0]           amplitude_i,
  output logic signed [SAMPLE_W-1:0] sample_o
);

  logic [1:0]             quadrant;
  logic [IDX_BITS-1:0]    idx_fwd;
  logic [ROM_AW-1:0]      idx;
  logic [ROM_W-1:0]       rom_val;
  logic [ROM_W+AMP_W-1:0] product;
  logic [SAMPLE_W-1:0]    mag;

  assign quadrant = phase_i[PHASE_BITS-1 -: 2];
  // Table index is the top bits of the position within the quadrant.
  assign idx_fwd  = phase_i[QUAD_BITS-1 -: IDX_BITS];

  always_comb begin
    if (quadrant[0]) begin
      idx = ROM_AW'(SINE_TABLE_DEPTH) - ROM_AW'(idx_fwd);
    end else begin
      idx = ROM_AW'(idx_fwd);
    end
  end

  assign rom_val = SINE_ROM[idx];
  assign product = (ROM_W+AMP_W)'(rom_val) * (ROM_W+AMP_W)'(amplitude_i);
  assign mag     = SAMPLE_W'(product[ROM_W+AMP_W-1:15]);

  // Second half period is negated; magnitude was already truncated.
  assign sample_o = quadrant[1] ? signed'(-mag) : signed'(mag);

endmodule

// ===== src/tone_burst_beep_sequencer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tone burst beep sequencer
// Plays bursts of sine beeps separated by silent gaps on a sample stream.
// ----------------------------------------------------------------------------
// Usage: each input word carries a sample tick together with optional start
// and stop requests. A start arms a burst of pip_count beeps (zero plays one),
// clears the phase and loads the tone length; a stop in the same word is
// applied first, so the start wins. A word with tick high gives exactly one
// output word: the sine sample, or zero in gaps, at beep ends and while idle.
// A word with tick low gives no output word but still applies its requests.
// Configuration writes set phase step, amplitude, tone length and gap length;
// the port is always ready and is meant to be written while no word is in
// flight.
// Timing: a word is held in the input register, the state update, the table
// lookup and the amplitude multiply happen in one pass, and the result is
// registered; one word is taken every cycle unless the receiver stalls.
// The single multiply after the table read sets the critical path.
// When the receiver stalls, the result register holds and the input register
// can still take one more word before ready drops. Reset clears all control
// state and returns the registers to their documented defaults.
// ----------------------------------------------------------------------------
module tone_burst_beep_sequencer_top
  import tbs_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Input words
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       tick_i,
  input  logic                       start_request_i,
  input  logic [3:0]                 pip_count_i,
  input  logic                       stop_request_i,
  // Result words
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [SAMPLE_W-1:0] sample_out_o,
  output logic                       tone_active_o,
  // Configuration writes
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [CFG_DATA_W-1:0]      cfg_data_i
);

  // Configuration registers.
  logic [15:0]      phase_step_q;
  logic [AMP_W-1:0] tone_amplitude_q;
  logic [15:0]      tone_length_q;
  logic [15:0]      gap_length_q;

  // Input register.
  logic       s1_valid_q;
  logic       s1_tick_q;
  logic       s1_start_q;
  logic [3:0] s1_count_q;
  logic       s1_stop_q;

  // Sequencer state.
  logic                  seq_active_q, seq_active_d;
  logic                  in_gap_q, in_gap_d;
  logic [15:0]           tone_left_q, tone_left_d;
  logic [15:0]           gap_left_q, gap_left_d;
  logic [BEEP_W-1:0]     beeps_left_q, beeps_left_d;
  logic [PHASE_BITS-1:0] phase_acc_q, phase_acc_d;

  // Result register.
  logic                       out_valid_q;
  logic signed [SAMPLE_W-1:0] sample_q, sample_d;
  logic                       active_q;

  // State after the start and stop requests of the word in hand.
  logic                  act_mid;
  logic                  gap_mid;
  logic [15:0]           tone_mid;
  logic [BEEP_W-1:0]     beeps_mid;
  logic [PHASE_BITS-1:0] phase_mid;
  logic [3:0]            count_sat;
  logic [BEEP_W-1:0]     beeps_dec;

  logic                       advance;
  logic signed [SAMPLE_W-1:0] sine_sample;

  // The input register moves on whenever the result register is free or
  // being emptied in this cycle.
  assign advance     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || advance;
  assign cfg_ready_o = 1'b1;

  assign out_valid_o   = out_valid_q;
  assign sample_out_o  = sample_q;
  assign tone_active_o = active_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q     <= RST_PHASE_STEP;
      tone_amplitude_q <= RST_TONE_AMPLITUDE;
      tone_length_q    <= RST_TONE_LENGTH;
      gap_length_q     <= RST_GAP_LENGTH;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_PHASE_STEP:     phase_step_q     <= cfg_data_i;
        REG_TONE_AMPLITUDE: tone_amplitude_q <= cfg_data_i[AMP_W-1:0];
        REG_TONE_LENGTH:    tone_length_q    <= cfg_data_i;
        REG_GAP_LENGTH:     gap_length_q     <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_tick_q  <= tick_i;
      s1_start_q <= start_request_i;
      s1_count_q <= pip_count_i;
      s1_stop_q  <= stop_request_i;
    end
  end

  tbs_sine u_sine (
    .phase_i     (phase_mid),
    .amplitude_i (tone_amplitude_q),
    .sample_o    (sine_sample)
  );

  always_comb begin
    // A zero count plays one beep; counts beyond the limit saturate.
    count_sat = (s1_count_q == 4'd0) ? 4'd1 : s1_count_q;
    if (32'(count_sat) > MAX_PIPS) begin
      count_sat = 4'(MAX_PIPS);
    end

    act_mid   = seq_active_q;
    gap_mid   = in_gap_q;
    tone_mid  = tone_left_q;
    beeps_mid = beeps_left_q;
    phase_mid = phase_acc_q;
    if (s1_stop_q) begin
      act_mid   = 1'b0;
      beeps_mid = '0;
      gap_mid   = 1'b0;
      phase_mid = '0;
    end
    if (s1_start_q) begin
      act_mid   = 1'b1;
      beeps_mid = BEEP_W'(count_sat);
      tone_mid  = tone_length_q;
      gap_mid   = 1'b0;
      phase_mid = '0;
    end

    seq_active_d = act_mid;
    in_gap_d     = gap_mid;
    tone_left_d  = tone_mid;
    gap_left_d   = gap_left_q;
    beeps_left_d = beeps_mid;
    phase_acc_d  = phase_mid;
    sample_d     = '0;
    beeps_dec    = (beeps_mid != '0) ? beeps_mid - 1'b1 : beeps_mid;

    if (s1_tick_q && act_mid) begin
      if (gap_mid) begin
        if (gap_left_q[15:1] == '0) begin
          gap_left_d  = '0;
          in_gap_d    = 1'b0;
          tone_left_d = tone_length_q;
        end else begin
          gap_left_d = gap_left_q - 16'd1;
        end
      end else if (tone_mid != '0) begin
        sample_d    = sine_sample;
        phase_acc_d = phase_mid + PHASE_BITS'(phase_step_q);
        tone_left_d = tone_mid - 16'd1;
      end else begin
        // End of a beep: either open the gap or finish the burst.
        beeps_left_d = beeps_dec;
        if (beeps_dec != '0) begin
          in_gap_d   = 1'b1;
          gap_left_d = gap_length_q;
        end else begin
          seq_active_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_active_q <= 1'b0;
      in_gap_q     <= 1'b0;
      tone_left_q  <= '0;
      gap_left_q   <= '0;
      beeps_left_q <= '0;
      phase_acc_q  <= '0;
    end else if (advance) begin
      seq_active_q <= seq_active_d;
      in_gap_q     <= in_gap_d;
      tone_left_q  <= tone_left_d;
      gap_left_q   <= gap_left_d;
      beeps_left_q <= beeps_left_d;
      phase_acc_q  <= phase_acc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_tick_q;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_tick_q) begin
      sample_q <= sample_d;
      active_q <= act_mid;
    end
  end

  // A gap only exists inside a running burst.
  a_gap_needs_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_gap_q |-> seq_active_q)
    else $error("gap flag set while the sequencer is idle");

  // A running burst always has at least one beep left to finish.
  a_active_has_beeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_active_q |-> (beeps_left_q != '0))
    else $error("sequencer armed with no beeps left");

  // An idle result word carries a silent sample.
  a_idle_is_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !active_q) |-> (sample_q == '0))
    else $error("non-zero sample while the sequencer is idle");

  // A word without a tick never produces a result.
  a_no_tick_no_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !s1_tick_q && out_ready_i) |=> !out_valid_q)
    else $error("result produced for a word without a tick");

endmodule
